/* rtl/tls_pkg.sv */
// Shared types and constants for the trainer link session core.
// No dependencies.
package tls_pkg;

  localparam int unsigned ReplyBytes = 64;
  localparam int unsigned RcW        = $clog2(ReplyBytes + 1);
  localparam int unsigned TimeW      = 63;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [6:0] MinDecode   = 7'd48;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QAw        = 2;

  // configuration register indexes
  localparam logic [2:0] RegDataHdr  = 3'd0;
  localparam logic [2:0] RegVerHdr   = 3'd1;
  localparam logic [2:0] RegMinBytes = 3'd2;
  localparam logic [2:0] RegFrameInt = 3'd3;
  localparam logic [2:0] RegVerRetry = 3'd4;
  localparam logic [2:0] RegPresTo   = 3'd5;
  localparam logic [2:0] RegVerLimit = 3'd6;

  typedef enum logic [1:0] {
    FnPoll  = 2'd0,
    FnWrote = 2'd1,
    FnByte  = 2'd2,
    FnTick  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KindNone    = 2'd0,
    KindFrame   = 2'd1,
    KindReply   = 2'd2,
    KindTick    = 2'd3
  } kind_e;

  // command from front to back
  typedef enum logic [2:0] {
    CmdNone  = 3'd0,
    CmdVer   = 3'd1,
    CmdStop  = 3'd2,
    CmdReply = 3'd3,
    CmdTick  = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  mask;
    logic [15:0] steering;
    logic [14:0] roll_speed;
    logic [14:0] cadence;
    logic [14:0] pulse;
    logic [15:0] resistance;
    logic [3:0]  buttons;
  } cmd_t;

  function automatic logic [TimeW-1:0] add_time(logic [TimeW-1:0] t, logic [31:0] d);
    logic [TimeW:0] s;
    s = {1'b0, t} + {{(TimeW-31){1'b0}}, d};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  function automatic logic [7:0] ver_byte(logic [3:0] k);
    return (k == 4'd0) ? 8'h02 : 8'h00;
  endfunction

  function automatic logic [7:0] stop_byte(logic [3:0] k);
    logic [7:0] b;
    case (k)
      4'd0: b = 8'h01;
      4'd1: b = 8'h08;
      4'd2: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/trainer_link_session_core.sv */
// Trainer link session core: top level joining front, queue and back parts.
// Depends on tls_pkg, tls_front, tls_queue, tls_back.
// Path: an item is queued on acceptance, then registered at the output when the output is free.
// Throughput: one item per cycle unless the queue is full; a granted poll gives 4 or 12 frame
// bytes, emitted one per cycle while the receiver is ready; the 4-entry queue absorbs bursts.
// Reset: asynchronous active low; clears state, counters and queue; sets register defaults.
module trainer_link_session_core import tls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [62:0] now_i,
  input  logic signed [7:0] written_count_i,
  input  logic [7:0]  reply_byte_i,
  input  logic        reply_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  output logic        frame_is_version_o,
  output logic [2:0]  changed_mask_o,
  output logic signed [15:0] steering_o,
  output logic [14:0] roll_speed_o,
  output logic [14:0] cadence_o,
  output logic [14:0] pulse_o,
  output logic signed [15:0] resistance_o,
  output logic [3:0]  buttons_o
);

  logic cmd_valid, q_full, q_empty, pop;
  cmd_t cmd, head;

  assign cfg_ready_o = 1'b1;

  tls_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .func_i, .now_i, .written_count_i,
    .reply_byte_i, .reply_last_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .q_full_i(q_full)
  );

  tls_queue u_queue (
    .clk_i, .rst_ni, .push_i(cmd_valid), .push_data_i(cmd), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .head_o(head)
  );

  tls_back u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .kind_o, .frame_byte_o, .frame_last_o,
    .frame_is_version_o, .changed_mask_o, .steering_o, .roll_speed_o,
    .cadence_o, .pulse_o, .resistance_o, .buttons_o
  );

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full |-> !cmd_valid)
    else $error("push into full queue");
  // a pop only when the queue holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("pop from empty queue");
  // version flag only on frame results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_is_version_o |-> kind_o == KindFrame)
    else $error("version flag on non-frame result");

endmodule

/* rtl/tls_front.sv */
// Front part: session state, reply buffering and decode; emits at most one command per item.
// Depends on tls_pkg.
module tls_front import tls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [TimeW-1:0]  now_i,
  input  logic signed [7:0] written_count_i,
  input  logic [7:0]        reply_byte_i,
  input  logic              reply_last_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              q_full_i
);

  localparam int unsigned KeepN = 21;

  logic [31:0] data_hdr_q, ver_hdr_q, frame_int_q, ver_retry_q, pres_to_q;
  logic [6:0]  min_bytes_q;
  logic [7:0]  ver_limit_q;

  logic [7:0]  keep_q [KeepN];
  logic [RcW-1:0] count_q;
  logic frame_fl_q, ver_fl_q, present_q, ver_known_q;
  logic [TimeW-1:0] next_frame_q, next_ver_q, last_data_q;
  logic [7:0]  tries_q;
  logic [31:0] fw_q, sn_q;
  logic [15:0] v2_q;

  logic acc;
  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_hdr_q <= '0; ver_hdr_q <= '0; min_bytes_q <= 7'd48;
      frame_int_q <= '0; ver_retry_q <= '0; pres_to_q <= '0; ver_limit_q <= 8'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDataHdr:  data_hdr_q  <= cfg_data_i;
        RegVerHdr:   ver_hdr_q   <= cfg_data_i;
        RegMinBytes: min_bytes_q <= cfg_data_i[6:0];
        RegFrameInt: frame_int_q <= cfg_data_i;
        RegVerRetry: ver_retry_q <= cfg_data_i;
        RegPresTo:   pres_to_q   <= cfg_data_i;
        RegVerLimit: ver_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // only bytes 12, 13, 18, 19, 24..39 and 44 feed the decode; others are dropped
  logic buf_we;
  assign buf_we = acc && (func_e'(func_i) == FnByte) && (count_q < RcW'(ReplyBytes));

  logic [4:0] wslot;
  logic       whit;
  always_comb begin
    wslot = '0;
    whit  = 1'b1;
    case (count_q)
      7'd12: wslot = 5'd0;
      7'd13: wslot = 5'd1;
      7'd18: wslot = 5'd2;
      7'd19: wslot = 5'd3;
      7'd44: wslot = 5'd20;
      default: begin
        if (count_q inside {[7'd24:7'd39]}) wslot = 5'(count_q - 7'd20);
        else whit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (buf_we && whit) keep_q[wslot] <= reply_byte_i;
  end

  // view of the kept bytes including the byte arriving now
  logic [7:0] kb [KeepN];
  always_comb begin
    for (int i = 0; i < KeepN; i++)
      kb[i] = (buf_we && whit && wslot == 5'(i)) ? reply_byte_i : keep_q[i];
  end

  logic [RcW-1:0] len;
  logic [6:0]     minlen;
  logic [31:0]    hdr, fw, sn;
  logic [15:0]    v2, ws, st, rs;
  logic is_data, is_ver, long_enough;
  assign len = buf_we ? count_q + 1'b1 : count_q;
  assign minlen = (min_bytes_q < MinDecode) ? MinDecode : min_bytes_q;
  assign long_enough = {{(8-RcW){1'b0}}, len} >= {1'b0, minlen};
  assign hdr = {kb[7], kb[6], kb[5], kb[4]};
  assign fw  = {kb[11], kb[10], kb[9], kb[8]};
  assign sn  = {kb[15], kb[14], kb[13], kb[12]};
  assign v2  = {kb[17], kb[16]};
  assign ws  = {kb[13], kb[12]};
  assign st  = {kb[3] ^ 8'h80, kb[2]};
  assign rs  = {kb[19], kb[18]};
  assign is_data = long_enough && (hdr == data_hdr_q);
  assign is_ver  = long_enough && !is_data && (hdr == ver_hdr_q);

  logic poll_ok, ver_sel, timeout;
  logic [TimeW:0] dead;
  assign poll_ok = !frame_fl_q && (now_i >= next_frame_q);
  assign ver_sel = !ver_known_q && (tries_q < ver_limit_q) && (now_i >= next_ver_q);
  assign dead = {1'b0, last_data_q} + {{(TimeW-31){1'b0}}, pres_to_q};
  assign timeout = present_q && ({1'b0, now_i} >= dead);

  // session state and command issue
  cmd_t cmd_d;
  logic cmd_v_d;
  always_comb begin
    cmd_d = '0;
    cmd_v_d = 1'b0;
    case (func_e'(func_i))
      FnPoll: begin
        cmd_v_d = 1'b1;
        cmd_d.cmd = !poll_ok ? CmdNone : (ver_sel ? CmdVer : CmdStop);
      end
      FnByte: begin
        cmd_v_d = reply_last_i;
        cmd_d.cmd = CmdReply;
        if (is_data) begin
          cmd_d.mask = {1'b0, !present_q, 1'b1};
          cmd_d.steering = st;
          cmd_d.roll_speed = ws[15] ? 15'h7FFF : ws[14:0];
          cmd_d.cadence = {kb[20], 7'd0};
          cmd_d.pulse = {kb[0], 7'd0};
          cmd_d.resistance = rs;
          cmd_d.buttons = kb[1][3:0];
        end else if (is_ver) begin
          cmd_d.mask[2] = !ver_known_q || fw != fw_q || sn != sn_q || v2 != v2_q;
        end
      end
      FnTick: begin
        cmd_v_d = 1'b1;
        cmd_d.cmd = CmdTick;
        cmd_d.mask = {1'b0, timeout, 1'b0};
      end
      default: ;
    endcase
  end
  assign cmd_valid_o = acc && cmd_v_d;
  assign cmd_o = cmd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; frame_fl_q <= 1'b0; ver_fl_q <= 1'b0; present_q <= 1'b0;
      ver_known_q <= 1'b0; next_frame_q <= '0; next_ver_q <= '0; last_data_q <= '0;
      tries_q <= '0; fw_q <= '0; sn_q <= '0; v2_q <= '0;
    end else if (acc) begin
      case (func_e'(func_i))
        FnPoll: begin
          if (poll_ok) begin
            frame_fl_q <= 1'b1;
            ver_fl_q <= ver_sel;
          end
        end
        FnWrote: begin
          if (frame_fl_q) begin
            frame_fl_q <= 1'b0;
            ver_fl_q <= 1'b0;
            next_frame_q <= add_time(now_i, frame_int_q);
            if (ver_fl_q && written_count_i == 8'sd4) begin
              if (tries_q != 8'hFF) tries_q <= tries_q + 8'd1;
              next_ver_q <= add_time(now_i, ver_retry_q);
            end
          end
        end
        FnByte: begin
          if (!reply_last_i) begin
            count_q <= len;
          end else begin
            count_q <= '0;
            if (is_data) begin
              last_data_q <= now_i;
              if (!present_q) begin
                present_q <= 1'b1;
                if (!ver_known_q && tries_q >= ver_limit_q) begin
                  tries_q <= '0;
                  next_ver_q <= now_i;
                end
              end
            end else if (is_ver) begin
              fw_q <= fw; sn_q <= sn; v2_q <= v2;
              ver_known_q <= 1'b1;
            end
          end
        end
        FnTick: begin
          if (timeout) begin
            present_q <= 1'b0;
            ver_known_q <= 1'b0;
            tries_q <= '0;
            next_ver_q <= now_i;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tls_queue.sv */
// Short command queue between front and back parts.
// Depends on tls_pkg.
module tls_queue import tls_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;

  assign full_o  = cnt_q == (QAw+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(push_i) - (QAw+1)'(pop_i);
    end
  end

endmodule

/* rtl/tls_back.sv */
// Back part: expands commands into result items through an output register.
// Depends on tls_pkg.
module tls_back import tls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o,
  output logic        frame_is_version_o,
  output logic [2:0]  changed_mask_o,
  output logic signed [15:0] steering_o,
  output logic [14:0] roll_speed_o,
  output logic [14:0] cadence_o,
  output logic [14:0] pulse_o,
  output logic signed [15:0] resistance_o,
  output logic [3:0]  buttons_o
);

  logic [3:0] idx_q;
  logic       ov_q;
  logic       load, is_frame, is_ver, last;

  assign load     = !empty_i && (!ov_q || out_ready_i);
  assign is_ver   = head_i.cmd == CmdVer;
  assign is_frame = is_ver || head_i.cmd == CmdStop;
  assign last     = !is_frame || idx_q == (is_ver ? 4'd3 : 4'd11);
  assign pop_o    = load && last;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; idx_q <= '0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        idx_q <= last ? 4'd0 : idx_q + 4'd1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      changed_mask_o <= head_i.mask;
      steering_o <= head_i.steering;
      roll_speed_o <= head_i.roll_speed;
      cadence_o <= head_i.cadence;
      pulse_o <= head_i.pulse;
      resistance_o <= head_i.resistance;
      buttons_o <= head_i.buttons;
      frame_byte_o <= is_ver ? ver_byte(idx_q) : (is_frame ? stop_byte(idx_q) : 8'h00);
      frame_last_o <= is_frame && last;
      frame_is_version_o <= is_ver;
      case (head_i.cmd)
        CmdVer, CmdStop: kind_o <= KindFrame;
        CmdReply:        kind_o <= KindReply;
        CmdTick:         kind_o <= KindTick;
        default:         kind_o <= KindNone;
      endcase
    end
  end

endmodule

/* test/tb_trainer_link_session_core.sv */
// Self-checking testbench for trainer_link_session_core: directed table, then random sessions.
// Depends on tls_pkg and the trainer_link_session_core RTL.
module tb_trainer_link_session_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tls_pkg::*;

  localparam int IdleLimit = 4000;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  fbyte;
    logic        flast;
    logic        fver;
    logic [2:0]  mask;
    logic [15:0] steer;
    logic [14:0] wspeed;
    logic [14:0] cad;
    logic [14:0] hrate;
    logic [15:0] resist;
    logic [3:0]  btn;
  } verdict_t;

  typedef struct {
    func_e       f;
    logic [62:0] t;
    logic [7:0]  wc;
    logic [7:0]  rb;
    logic        rl;
    bit          fixed;
    verdict_t    want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = '0;
  logic [62:0] now_i = '0;
  logic signed [7:0] written_count_i = '0;
  logic [7:0] reply_byte_i = '0;
  logic reply_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] frame_byte_o;
  logic frame_last_o, frame_is_version_o;
  logic [2:0] changed_mask_o;
  logic signed [15:0] steering_o, resistance_o;
  logic [14:0] roll_speed_o, cadence_o, pulse_o;
  logic [3:0] buttons_o;

  trainer_link_session_core u_dut (.*);

  always #2 clk_i = ~clk_i;

  // session mirror
  logic [31:0] m_data_hdr, m_ver_hdr, m_frame_int, m_retry, m_pres_to;
  logic [6:0]  m_min_bytes;
  logic [7:0]  m_ver_limit;
  logic [7:0]  m_buf [ReplyBytes];
  int unsigned m_count;
  logic        m_frame_busy, m_ver_busy, m_present, m_ver_known;
  logic [62:0] m_next_frame, m_next_ver, m_last_data;
  logic [7:0]  m_tries;
  logic [31:0] m_fw, m_sn;
  logic [15:0] m_v2;

  verdict_t expected_q[$];
  verdict_t step_q[$];
  row_t     rows[$];
  int n_items, n_results, n_errors, n_decoded;
  logic [62:0] clock_now;
  bit calm;

  function automatic logic [62:0] t_plus(logic [62:0] t, logic [31:0] d);
    logic [63:0] s;
    s = {1'b0, t} + {32'd0, d};
    return s[63] ? {63{1'b1}} : s[62:0];
  endfunction

  function automatic logic [15:0] w16(int at);
    return {m_buf[at+1], m_buf[at]};
  endfunction

  function automatic logic [7:0] stop_frame(int k);
    case (k)
      0: return 8'h01;
      1: return 8'h08;
      2: return 8'h01;
      default: return 8'h00;
    endcase
  endfunction

  // work out the results of one accepted item into step_q
  task automatic session_step(func_e f, logic [62:0] t, logic [7:0] wc, logic [7:0] rb,
                              logic rl);
    verdict_t r;
    bit ver;
    int n, len, minl;
    logic [31:0] hdr, fw, sn;
    logic [15:0] ws, v2;
    r = '0;
    step_q.delete();
    case (f)
      FnPoll: begin
        if (m_frame_busy || t < m_next_frame) begin
          r.kind = KindNone;
          step_q.push_back(r);
        end else begin
          ver = !m_ver_known && m_tries < m_ver_limit && t >= m_next_ver;
          m_ver_busy = ver;
          m_frame_busy = 1'b1;
          n = ver ? 4 : 12;
          for (int k = 0; k < n; k++) begin
            r = '0;
            r.kind = KindFrame;
            r.fbyte = ver ? ((k == 0) ? 8'h02 : 8'h00) : stop_frame(k);
            r.flast = (k == n - 1);
            r.fver = ver;
            step_q.push_back(r);
          end
        end
      end
      FnWrote: begin
        if (m_frame_busy) begin
          m_frame_busy = 1'b0;
          m_next_frame = t_plus(t, m_frame_int);
          if (m_ver_busy && wc == 8'd4) begin
            if (m_tries < 8'd255) m_tries++;
            m_next_ver = t_plus(t, m_retry);
          end
          m_ver_busy = 1'b0;
        end
      end
      FnByte: begin
        if (m_count < ReplyBytes) begin
          m_buf[m_count] = rb;
          m_count++;
        end
        if (rl) begin
          len = m_count;
          m_count = 0;
          minl = (m_min_bytes < 7'd48) ? 48 : m_min_bytes;
          r.kind = KindReply;
          if (len >= minl) begin
            hdr = {w16(26), w16(24)};
            if (hdr == m_data_hdr) begin
              n_decoded++;
              ws = w16(32);
              m_last_data = t;
              r.mask[0] = 1'b1;
              if (!m_present) begin
                m_present = 1'b1;
                r.mask[1] = 1'b1;
                if (!m_ver_known && m_tries >= m_ver_limit) begin
                  m_tries = '0;
                  m_next_ver = t;
                end
              end
              r.steer = w16(18) ^ 16'h8000;
              r.wspeed = (ws > 16'd32767) ? 15'h7FFF : ws[14:0];
              r.cad = {m_buf[44], 7'd0};
              r.hrate = {m_buf[12], 7'd0};
              r.resist = w16(38);
              r.btn = m_buf[13][3:0];
            end else if (hdr == m_ver_hdr) begin
              n_decoded++;
              fw = {w16(30), w16(28)};
              sn = {w16(34), w16(32)};
              v2 = w16(36);
              if (!m_ver_known || fw != m_fw || sn != m_sn || v2 != m_v2) r.mask[2] = 1'b1;
              m_fw = fw;
              m_sn = sn;
              m_v2 = v2;
              m_ver_known = 1'b1;
            end
          end
          step_q.push_back(r);
        end
      end
      default: begin
        r.kind = KindTick;
        if (m_present && {1'b0, t} >= {1'b0, m_last_data} + {32'd0, m_pres_to}) begin
          m_present = 1'b0;
          m_ver_known = 1'b0;
          m_tries = '0;
          m_next_ver = t;
          r.mask = 3'd2;
        end
        step_q.push_back(r);
      end
    endcase
  endtask

  // send one item; on acceptance, predict (or take the typed expectation)
  task automatic send_item(func_e f, logic [62:0] t, logic [7:0] wc, logic [7:0] rb, logic rl,
                           bit fixed = 0, verdict_t want = '0);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    now_i <= t;
    written_count_i <= wc;
    reply_byte_i <= rb;
    reply_last_i <= rl;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    session_step(f, t, wc, rb, rl);
    if (fixed && step_q.size() == 1) step_q[0] = want;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegDataHdr:  m_data_hdr = val;
      RegVerHdr:   m_ver_hdr = val;
      RegMinBytes: m_min_bytes = val[6:0];
      RegFrameInt: m_frame_int = val;
      RegVerRetry: m_retry = val;
      RegPresTo:   m_pres_to = val;
      RegVerLimit: m_ver_limit = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [7:0] any_wc();
    return 8'($urandom_range(0, 65)) - 8'd1;
  endfunction

  // one reply of len bytes; header at 24..27, identity bytes optionally fixed
  task automatic send_reply(int len, logic [31:0] hdr, bit fixed_id);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i >= 24 && i <= 27) b = hdr[8*(i-24) +: 8];
      else if (fixed_id && i >= 28 && i <= 37) b = 8'(i * 7);
      send_item(FnByte, clock_now, any_wc(), b, i == len - 1);
    end
  endtask

  task automatic add_row(func_e f, logic [62:0] t, logic [7:0] wc, logic [7:0] rb, logic rl,
                         bit fixed = 0, kind_e k = KindNone, logic [2:0] mask = '0);
    row_t r;
    r.f = f; r.t = t; r.wc = wc; r.rb = rb; r.rl = rl; r.fixed = fixed;
    r.want = '0;
    r.want.kind = k;
    r.want.mask = mask;
    rows.push_back(r);
  endtask

  // result checker
  task automatic check_field(string name, logic [15:0] e, logic [15:0] a, inout bit bad);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      bad = 1;
    end
  endtask

  always @(posedge clk_i) begin
    verdict_t e;
    bit bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, kind %0d", $time, kind_o);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        bad = 0;
        check_field("kind", e.kind, kind_o, bad);
        check_field("frame_byte", e.fbyte, frame_byte_o, bad);
        check_field("frame_last", e.flast, frame_last_o, bad);
        check_field("frame_is_version", e.fver, frame_is_version_o, bad);
        check_field("changed_mask", e.mask, changed_mask_o, bad);
        check_field("steering", e.steer, steering_o, bad);
        check_field("roll_speed", e.wspeed, roll_speed_o, bad);
        check_field("cadence", e.cad, cadence_o, bad);
        check_field("pulse", e.hrate, pulse_o, bad);
        check_field("resistance", e.resist, resistance_o, bad);
        check_field("buttons", e.btn, buttons_o, bad);
        if (bad) n_errors++;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(0, 99) >= 11);

  // watchdog on cycles without any handshake
  int quiet;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= IdleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [62:0] tmax;
    logic [31:0] id_hdr;
    int op, len;
    tmax = {63{1'b1}};
    m_data_hdr = '0; m_ver_hdr = '0; m_min_bytes = 7'd48;
    m_frame_int = '0; m_retry = '0; m_pres_to = '0; m_ver_limit = 8'd3;
    m_count = 0;
    m_frame_busy = 0; m_ver_busy = 0; m_present = 0; m_ver_known = 0;
    m_next_frame = '0; m_next_ver = '0; m_last_data = '0;
    m_tries = '0; m_fw = '0; m_sn = '0; m_v2 = '0;
    quiet = 0;
    calm = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, reset register values (equal headers: data decode wins)
    add_row(FnTick, '0, 8'd0, 8'd0, 1'b0, 1, KindTick, 3'd0);
    add_row(FnWrote, '0, 8'd4, 8'd0, 1'b0);
    add_row(FnPoll, '0, 8'd0, 8'd0, 1'b0);
    add_row(FnPoll, '0, 8'd0, 8'd0, 1'b0, 1, KindNone, 3'd0);
    add_row(FnWrote, 63'd5, 8'd4, 8'd0, 1'b0);
    add_row(FnPoll, tmax, 8'hFF, 8'hFF, 1'b1);
    add_row(FnWrote, tmax, 8'hFF, 8'd0, 1'b0);
    add_row(FnPoll, tmax, 8'd64, 8'd0, 1'b0);
    add_row(FnWrote, 63'd9, 8'd12, 8'd0, 1'b0);
    add_row(FnPoll, 63'd9, 8'd0, 8'd0, 1'b0);
    add_row(FnWrote, 63'd9, 8'd4, 8'd0, 1'b0);
    add_row(FnPoll, 63'd10, 8'd0, 8'd0, 1'b0);
    add_row(FnWrote, 63'd10, 8'h80, 8'd0, 1'b0);
    add_row(FnByte, '0, 8'd0, 8'hFF, 1'b1, 1, KindReply, 3'd0);
    add_row(FnByte, tmax, 8'd0, 8'h00, 1'b0);
    add_row(FnByte, tmax, 8'd0, 8'hA5, 1'b1, 1, KindReply, 3'd0);
    add_row(FnTick, tmax, 8'hFF, 8'hFF, 1'b1, 1, KindTick, 3'd0);
    foreach (rows[i]) begin
      send_item(rows[i].f, rows[i].t, rows[i].wc, rows[i].rb, rows[i].rl,
                rows[i].fixed, rows[i].want);
    end
    drain();

    // random sessions, one register setting per phase
    clock_now = 63'd100;
    for (int p = 0; p < 5; p++) begin
      calm = (p == 1);
      case (p)
        0: begin
          write_reg(RegDataHdr, $urandom); write_reg(RegVerHdr, $urandom);
          write_reg(RegMinBytes, 32'd48); write_reg(RegFrameInt, 32'd0);
          write_reg(RegVerRetry, 32'd0); write_reg(RegPresTo, 32'd0);
          write_reg(RegVerLimit, 32'd3);
        end
        1: begin
          write_reg(RegDataHdr, 32'hFFFF_FFFF); write_reg(RegVerHdr, 32'h0);
          write_reg(RegMinBytes, 32'd64); write_reg(RegFrameInt, 32'd10);
          write_reg(RegVerRetry, 32'd30); write_reg(RegPresTo, 32'd100);
          write_reg(RegVerLimit, 32'd0);
        end
        2: begin
          id_hdr = $urandom;
          write_reg(RegDataHdr, id_hdr); write_reg(RegVerHdr, id_hdr);
          write_reg(RegMinBytes, 32'd0); write_reg(RegFrameInt, 32'hFFFF_FFFF);
          write_reg(RegVerRetry, 32'hFFFF_FFFF); write_reg(RegPresTo, 32'd30);
          write_reg(RegVerLimit, 32'd255);
          clock_now = tmax - 63'd2000;
        end
        3: begin
          write_reg(RegMinBytes, 32'd127); write_reg(RegFrameInt, $urandom_range(0, 8));
          write_reg(RegVerRetry, $urandom_range(0, 8));
          write_reg(RegPresTo, $urandom_range(0, 50));
        end
        default: begin
          write_reg(RegDataHdr, $urandom); write_reg(RegVerHdr, $urandom);
          write_reg(RegMinBytes, 32'd50); write_reg(RegFrameInt, 32'd3);
          write_reg(RegVerRetry, 32'd5); write_reg(RegPresTo, 32'd40);
          write_reg(RegVerLimit, 32'd1);
          clock_now = 63'd500;
        end
      endcase
      // full-length replies: a data reply with a presence timeout after it, a version reply
      if (p == 2) begin
        send_reply(48, m_data_hdr, 0);
        clock_now = t_plus(clock_now, 32'd40);
        send_item(FnTick, clock_now, any_wc(), 8'($urandom), 1'($urandom));
      end else if (p == 4) begin
        send_reply(50, m_ver_hdr, $urandom_range(0, 1));
      end
      for (int s = 0; s < 3; s++) begin
        clock_now = t_plus(clock_now, $urandom_range(0, 20));
        op = $urandom_range(0, 9);
        len = $urandom_range(1, 5);
        if (op < 4) begin
          send_item(FnPoll, clock_now, any_wc(), 8'($urandom), 1'($urandom));
          clock_now = t_plus(clock_now, $urandom_range(0, 3));
          send_item(FnWrote, clock_now,
                    ($urandom_range(0, 4) != 0) ? (m_ver_busy ? 8'd4 : 8'd12) : any_wc(),
                    8'($urandom), 1'($urandom));
        end else if (op < 6) begin
          send_reply(len, m_data_hdr, 0);
        end else if (op < 7) begin
          send_reply(len, m_ver_hdr, $urandom_range(0, 1));
        end else if (op < 9) begin
          send_item(FnTick, clock_now, any_wc(), 8'($urandom), 1'($urandom));
        end else begin
          // a stray item of a random kind; as a byte it closes any reply it lands in
          send_item(func_e'($urandom_range(0, 3)),
                    ($urandom_range(0, 1) != 0) ? 63'({$urandom, $urandom}) : clock_now,
                    any_wc(), 8'($urandom), 1'b1);
        end
      end
      // sender holds off until every result of the phase has come back
      drain();
    end
    calm = 0;
    repeat (20) @(negedge clk_i);

    $display("Sent %0d items over five register settings; %0d results checked.",
             n_items, n_results);
    $display("Decoded replies: %0d; leftover expectations: %0d.", n_decoded, expected_q.size());
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
